// ===== src/spbd_pkg.sv =====
`timescale 1ns / 1ps
// Package: shared types, codes and the segment table of the status panel blink driver.
package spbd_pkg;

   typedef enum logic [1:0] {
      OP_SET     = 2'd0,
      OP_TICK    = 2'd1,
      OP_REFRESH = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_OFF   = 2'd0,
      MODE_ON    = 2'd1,
      MODE_BLINK = 2'd2
   } mode_type;

   localparam logic [7:0] FAULT_FIRST  = 8'd101;
   localparam logic [7:0] FAULT_C      = 8'd112;
   localparam logic [7:0] FAULT_LAST   = 8'd113;
   localparam logic [7:0] CODE_BASE    = 8'd100;
   localparam logic [7:0] CODE_BASE2   = 8'd200;
   localparam logic [3:0] IDX_C        = 4'd13;
   localparam logic [3:0] IDX_D        = 4'd14;
   localparam logic [6:0] IDX_MAX      = 7'd14;
   localparam logic [7:0] SEG_BLANK    = 8'hFF;
   localparam logic [7:0] SEG_EIGHT    = 8'h80;
   localparam logic [7:0] BLUE_MASK    = 8'h7F;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] status_code;
   } req_type;

   typedef struct packed {
      logic       red_pin;
      logic [7:0] shift_levels;
      logic       shift_valid;
      logic       buzzer_pulse;
   } rsp_type;

   // Segment patterns, active low; bit 7 doubles as the blue lamp line.
   function automatic logic [7:0] seg_pattern(input logic [3:0] idx);
      logic [7:0] pat;
      case (idx)
         4'd0:    pat = 8'hF7;
         4'd1:    pat = 8'hBE;
         4'd2:    pat = 8'hC4;
         4'd3:    pat = 8'hA4;
         4'd4:    pat = 8'hB2;
         4'd5:    pat = 8'hA1;
         4'd6:    pat = 8'h81;
         4'd7:    pat = 8'hBC;
         4'd8:    pat = 8'h80;
         4'd9:    pat = 8'hB0;
         4'd10:   pat = 8'h90;
         4'd11:   pat = 8'h83;
         4'd12:   pat = 8'hFF;
         4'd13:   pat = 8'hC9;
         4'd14:   pat = 8'h86;
         default: pat = SEG_BLANK;
      endcase
      return pat;
   endfunction

endpackage

// ===== src/spbd_if.sv =====
`timescale 1ns / 1ps
// Interfaces: valid/ready channels for requests and responses.
interface spbd_req_if;
   logic             valid;
   logic             ready;
   spbd_pkg::req_type data;

   modport source  (output valid, output data, input ready);
   modport sink    (input valid, input data, output ready);
   modport monitor (input valid, input data, input ready);
endinterface

interface spbd_rsp_if;
   logic             valid;
   logic             ready;
   spbd_pkg::rsp_type data;

   modport source  (output valid, output data, input ready);
   modport sink    (input valid, input data, output ready);
   modport monitor (input valid, input data, input ready);
endinterface

// ===== src/status_panel_blink_driver.sv =====
`timescale 1ns / 1ps
// Top level: status panel blink driver (lamp modes, blink phases, refresh frames).
//
// Each request transfer (set status code, blink tick or refresh) yields exactly one
// response transfer from a single output register. The block takes one request per
// cycle: a new transfer is accepted whenever the output register is empty or its
// contents are being taken in the same cycle, so with a ready consumer the
// throughput is one item per clock. The panel state (lamp modes, segment pattern,
// blink phases, beep mark) updates at the edge where the request transfer completes.
// Refresh responses carry the red line level and the eight inverted data-line levels,
// MSB first; all other responses carry zeros there.
// There are no configuration registers; reset turns all lamps on with the digit showing 8.
module status_panel_blink_driver (
   input  logic              clock,
   input  logic              reset,
   spbd_req_if.sink          req_port,
   spbd_rsp_if.source        rsp_port
);

   // Panel state
   spbd_pkg::mode_type red_mode_ff,   red_mode_in;
   spbd_pkg::mode_type blue_mode_ff,  blue_mode_in;
   spbd_pkg::mode_type digit_mode_ff, digit_mode_in;
   logic               buzzer_blinks_ff, buzzer_blinks_in;
   logic [7:0]         segment_pattern_ff, segment_pattern_in;
   logic               red_phase_ff,  red_phase_in;
   logic               blue_dark_ff,  blue_dark_in;
   logic               digit_dark_ff, digit_dark_in;
   logic               beep_done_ff,  beep_done_in;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   spbd_pkg::rsp_type  rsp_data_ff,  rsp_data_in;

   logic               accept;
   logic [7:0]         code;
   logic [6:0]         code_rem;
   logic               is_fault;
   logic [3:0]         fault_idx;
   logic               red_blinks, blue_blinks, digit_blinks;
   logic [7:0]         frame;

   // Accept while the output register is free or draining this cycle.
   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign accept         = req_port.valid && req_port.ready;

   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.data  = rsp_data_ff;

   assign code = req_port.data.status_code;

   // Code mod 100 for an 8-bit value: at most one subtraction, of 100 or of 200.
   always_comb begin
      if (code >= spbd_pkg::CODE_BASE2) begin
         code_rem = 7'(code - spbd_pkg::CODE_BASE2);
      end else if (code >= spbd_pkg::CODE_BASE) begin
         code_rem = 7'(code - spbd_pkg::CODE_BASE);
      end else begin
         code_rem = code[6:0];
      end
   end

   assign is_fault = (code >= spbd_pkg::FAULT_FIRST) && (code <= spbd_pkg::FAULT_LAST);

   // Fault codes 112 and 113 skip the blank entry and land on C and d.
   always_comb begin
      if (code == spbd_pkg::FAULT_C) begin
         fault_idx = spbd_pkg::IDX_C;
      end else if (code == spbd_pkg::FAULT_LAST) begin
         fault_idx = spbd_pkg::IDX_D;
      end else begin
         fault_idx = code_rem[3:0];
      end
   end

   // Any mode other than off or on behaves as blink.
   assign red_blinks   = (red_mode_ff   != spbd_pkg::MODE_OFF) && (red_mode_ff   != spbd_pkg::MODE_ON);
   assign blue_blinks  = (blue_mode_ff  != spbd_pkg::MODE_OFF) && (blue_mode_ff  != spbd_pkg::MODE_ON);
   assign digit_blinks = (digit_mode_ff != spbd_pkg::MODE_OFF) && (digit_mode_ff != spbd_pkg::MODE_ON);

   always_comb begin
      // Hold state by default
      red_mode_in        = red_mode_ff;
      blue_mode_in       = blue_mode_ff;
      digit_mode_in      = digit_mode_ff;
      buzzer_blinks_in   = buzzer_blinks_ff;
      segment_pattern_in = segment_pattern_ff;
      red_phase_in       = red_phase_ff;
      blue_dark_in       = blue_dark_ff;
      digit_dark_in      = digit_dark_ff;
      beep_done_in       = beep_done_ff;
      rsp_data_in        = '0;
      frame              = spbd_pkg::SEG_BLANK;

      case (spbd_pkg::opcode_type'(req_port.data.opcode))
         spbd_pkg::OP_SET: begin
            if (is_fault) begin
               // Fault: red and digit blink, blue off, buzzer blinks except on the first fault.
               buzzer_blinks_in   = (code != spbd_pkg::FAULT_FIRST);
               digit_mode_in      = spbd_pkg::MODE_BLINK;
               red_mode_in        = spbd_pkg::MODE_BLINK;
               blue_mode_in       = spbd_pkg::MODE_OFF;
               segment_pattern_in = spbd_pkg::seg_pattern(fault_idx);
            end else begin
               buzzer_blinks_in = 1'b0;
               digit_mode_in    = spbd_pkg::MODE_ON;
               if (code_rem != '0) begin
                  red_mode_in  = spbd_pkg::MODE_ON;
                  blue_mode_in = spbd_pkg::MODE_ON;
               end else begin
                  red_mode_in  = spbd_pkg::MODE_BLINK;
                  blue_mode_in = spbd_pkg::MODE_OFF;
               end
               // Saturate indexes beyond the table to blank.
               if (code_rem <= spbd_pkg::IDX_MAX) begin
                  segment_pattern_in = spbd_pkg::seg_pattern(code_rem[3:0]);
               end else begin
                  segment_pattern_in = spbd_pkg::SEG_BLANK;
               end
            end
         end
         spbd_pkg::OP_TICK: begin
            if (red_blinks) begin
               red_phase_in = !red_phase_ff;
            end
            if (blue_blinks) begin
               blue_dark_in = !blue_dark_ff;
            end
            if (digit_blinks) begin
               if (digit_dark_ff) begin
                  // Blink-on edge of the digit: beep once per edge.
                  digit_dark_in = 1'b0;
                  if (!beep_done_ff) begin
                     beep_done_in             = 1'b1;
                     rsp_data_in.buzzer_pulse = buzzer_blinks_ff;
                  end
               end else begin
                  digit_dark_in = 1'b1;
                  beep_done_in  = 1'b0;
               end
            end
         end
         spbd_pkg::OP_REFRESH: begin
            case (red_mode_ff)
               spbd_pkg::MODE_OFF: rsp_data_in.red_pin = 1'b0;
               spbd_pkg::MODE_ON:  rsp_data_in.red_pin = 1'b1;
               default:            rsp_data_in.red_pin = !red_phase_ff;
            endcase
            // Settle steady lamps; blinking lamps keep their phase.
            if (blue_mode_ff == spbd_pkg::MODE_OFF) begin
               blue_dark_in = 1'b1;
            end else if (blue_mode_ff == spbd_pkg::MODE_ON) begin
               blue_dark_in = 1'b0;
            end
            if (digit_mode_ff == spbd_pkg::MODE_OFF) begin
               digit_dark_in = 1'b1;
            end else if (digit_mode_ff == spbd_pkg::MODE_ON) begin
               digit_dark_in = 1'b0;
            end
            frame = digit_dark_in ? spbd_pkg::SEG_BLANK : segment_pattern_ff;
            // Blue lamp shares bit 7 with the digit byte.
            if (!blue_dark_in) begin
               frame = frame & spbd_pkg::BLUE_MASK;
            end
            rsp_data_in.shift_levels = ~frame;
            rsp_data_in.shift_valid  = 1'b1;
         end
         default: begin
            // Unused opcode: drop, answer with zeros.
         end
      endcase
   end

   // Advance the valid flag: load on accept, clear once taken.
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_mode_ff        <= spbd_pkg::MODE_ON;
         blue_mode_ff       <= spbd_pkg::MODE_ON;
         digit_mode_ff      <= spbd_pkg::MODE_ON;
         buzzer_blinks_ff   <= 1'b0;
         segment_pattern_ff <= spbd_pkg::SEG_EIGHT;
         red_phase_ff       <= 1'b0;
         blue_dark_ff       <= 1'b0;
         digit_dark_ff      <= 1'b0;
         beep_done_ff       <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            red_mode_ff        <= red_mode_in;
            blue_mode_ff       <= blue_mode_in;
            digit_mode_ff      <= digit_mode_in;
            buzzer_blinks_ff   <= buzzer_blinks_in;
            segment_pattern_ff <= segment_pattern_in;
            red_phase_ff       <= red_phase_in;
            blue_dark_ff       <= blue_dark_in;
            digit_dark_ff      <= digit_dark_in;
            beep_done_ff       <= beep_done_in;
         end
      end
   end

   // Payload register needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== src/spbd_checker.sv =====
`timescale 1ns / 1ps
// Checker: port-level properties of the status panel blink driver, bound to the top level.
module spbd_checker (
   input logic          clock,
   input logic          reset,
   spbd_req_if.sink     req_port,
   spbd_rsp_if.source   rsp_port
);

   logic req_xfer;
   assign req_xfer = req_port.valid && req_port.ready;

   // No response right after reset.
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_port.valid)
      else $error("response valid directly after reset");

   // A refresh transfer shows a refresh frame on the next cycle.
   a_refresh_frame: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_port.data.opcode == spbd_pkg::OP_REFRESH)
      |=> rsp_port.valid && rsp_port.data.shift_valid && !rsp_port.data.buzzer_pulse)
      else $error("refresh transfer without refresh frame");

   // A set transfer answers with an all-zero response.
   a_set_quiet: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_port.data.opcode == spbd_pkg::OP_SET)
      |=> rsp_port.valid && (rsp_port.data == '0))
      else $error("set transfer produced a non-zero response");

   // Outside refresh frames the pin and data levels stay low.
   a_idle_lines: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && !rsp_port.data.shift_valid
      |-> !rsp_port.data.red_pin && (rsp_port.data.shift_levels == '0))
      else $error("line levels driven outside a refresh frame");

endmodule

bind status_panel_blink_driver spbd_checker u_spbd_checker (
   .clock    (clock),
   .reset    (reset),
   .req_port (req_port),
   .rsp_port (rsp_port)
);
